@@ rtl/htfr_pkg.sv @@
// Package for the humidity/temperature frame reader.
// Holds status and action codes, conversion constants and the CRC-8 helper.
// No dependencies; compiled first.
package htfr_pkg;

  // Result status codes.
  localparam logic [2:0] ST_PENDING = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd1;
  localparam logic [2:0] ST_CORRUPT = 3'd2;
  localparam logic [2:0] ST_COMM    = 3'd3;
  localparam logic [2:0] ST_IDLE    = 3'd4;

  // Input action codes.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  // Measurement kind codes.
  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_HUM  = 1'b1;

  // CRC-8 polynomial (x^8 + x^5 + x^4 + 1), init zero, MSB first.
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Status bits cleared from the low data byte.
  localparam logic [7:0] LSB_MASK_TEMP = 8'hFC;
  localparam logic [7:0] LSB_MASK_HUM  = 8'hF0;

  // Fixed-point conversion in hundredths: offset + (scale * raw) >> 16.
  localparam logic [14:0]        SCALE_TEMP  = 15'd17572;
  localparam logic [14:0]        SCALE_HUM   = 15'd12500;
  localparam logic signed [15:0] OFFSET_TEMP = -16'sd4685;
  localparam logic signed [15:0] OFFSET_HUM  = -16'sd600;

  // Reset value of the retry limit.
  localparam logic [7:0] MAX_RETRY_RST = 8'd30;

  // One registered input item.
  typedef struct packed {
    logic       action;
    logic       kind;
    logic       write_ok;
    logic       data_ready;
    logic [7:0] msb;
    logic [7:0] lsb;
    logic [7:0] check_byte;
  } in_item_t;

  // Fold one byte into a running CRC-8.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    crc = crc_in ^ data;
    for (int b = 0; b < 8; b++) begin
      if (crc[7]) begin
        crc = {crc[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

@@ rtl/htfr_chan_if.sv @@
// Channel interfaces of the humidity/temperature frame reader.
// Input item, result item and configuration write channels.
// Depends on nothing; compiled after htfr_pkg.

// Input item channel.
interface htfr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic       kind;
  logic       write_ok;
  logic       data_ready;
  logic [7:0] msb;
  logic [7:0] lsb;
  logic [7:0] check_byte;

  modport source (output valid, action, kind, write_ok, data_ready, msb, lsb, check_byte,
                  input ready);
  modport sink (input valid, action, kind, write_ok, data_ready, msb, lsb, check_byte,
                output ready);
endinterface

// Result item channel.
interface htfr_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [14:0] value;
  logic [15:0]        raw_code;
  logic               was_humidity;

  modport source (output valid, status, value, raw_code, was_humidity, input ready);
  modport sink (input valid, status, value, raw_code, was_humidity, output ready);
endinterface

// Configuration write channel for the retry limit.
interface htfr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/humidity_temp_frame_reader_unit.sv @@
// Top level of the humidity/temperature frame reader.
// Depends on htfr_pkg and the channel interfaces in htfr_chan_if.sv.
//
//   channel  | direction | transfer carries
//   ---------+-----------+----------------------------------------------
//   in_if    | sink      | action, kind, write_ok, data_ready, 3 bytes
//   out_if   | source    | status, value, raw_code, was_humidity
//   cfg_if   | sink      | max_retry (8 bits), always ready
//
// Each item passes from input transfer to result through the input
// register; then the exchange state update, CRC check and the single
// 16x15 conversion multiply feed the result register.
// One item is accepted every cycle; a stalled result holds the input
// register, and the input accepts again as soon as the result is taken.
// rst_n is synchronous and active low; the retry limit resets to 30.
module humidity_temp_frame_reader_unit
  import htfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  htfr_in_if.sink    in_if,
  htfr_out_if.source out_if,
  htfr_cfg_if.sink   cfg_if
);

  // Input register stage.
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     s1_adv;

  // Exchange state.
  logic       busy_r, busy_nxt;
  logic       pend_kind_r, pend_kind_nxt;
  logic [7:0] attempts_r, attempts_nxt;
  logic [7:0] max_retry_r;

  // Result register.
  logic               out_valid_r;
  logic [2:0]         status_r, status_nxt;
  logic signed [14:0] value_r, value_nxt;
  logic [15:0]        raw_r, raw_nxt;
  logic               hum_r, hum_nxt;

  // Datapath intermediates.
  logic [7:0]         crc_calc;
  logic [7:0]         att_inc;
  logic               kind_sel;
  logic [15:0]        raw_masked;
  logic [14:0]        scale;
  logic [30:0]        product;
  logic signed [15:0] offset;
  logic signed [15:0] value_full;

  // The input register moves on when the result register is free or being taken.
  assign s1_adv      = !out_valid_r || out_if.ready;
  assign in_if.ready = !s1_valid_r || s1_adv;
  assign cfg_if.ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
    if (in_if.valid && in_if.ready) begin
      s1_item_r.action     <= in_if.action;
      s1_item_r.kind       <= in_if.kind;
      s1_item_r.write_ok   <= in_if.write_ok;
      s1_item_r.data_ready <= in_if.data_ready;
      s1_item_r.msb        <= in_if.msb;
      s1_item_r.lsb        <= in_if.lsb;
      s1_item_r.check_byte <= in_if.check_byte;
    end
  end

  // CRC over the two data bytes and the conversion of the masked raw code.
  always_comb begin
    crc_calc   = crc8_byte(crc8_byte(8'h00, s1_item_r.msb), s1_item_r.lsb);
    att_inc    = (attempts_r == 8'hFF) ? attempts_r : attempts_r + 8'd1;
    kind_sel   = pend_kind_r;
    if (kind_sel == KIND_HUM) begin
      raw_masked = {s1_item_r.msb, s1_item_r.lsb & LSB_MASK_HUM};
      scale      = SCALE_HUM;
      offset     = OFFSET_HUM;
    end else begin
      raw_masked = {s1_item_r.msb, s1_item_r.lsb & LSB_MASK_TEMP};
      scale      = SCALE_TEMP;
      offset     = OFFSET_TEMP;
    end
    product    = 31'(raw_masked) * 31'(scale);
    value_full = offset + $signed({1'b0, product[30:16]});
  end

  // Exchange state update and result selection.
  always_comb begin
    busy_nxt      = busy_r;
    pend_kind_nxt = pend_kind_r;
    attempts_nxt  = attempts_r;
    status_nxt    = ST_IDLE;
    value_nxt     = '0;
    raw_nxt       = '0;
    hum_nxt       = 1'b0;
    if (s1_item_r.action == ACT_START) begin
      attempts_nxt = '0;
      hum_nxt      = s1_item_r.kind;
      if (s1_item_r.write_ok) begin
        busy_nxt      = 1'b1;
        pend_kind_nxt = s1_item_r.kind;
        status_nxt    = ST_PENDING;
      end else begin
        busy_nxt   = 1'b0;
        status_nxt = ST_COMM;
      end
    end else if (!busy_r) begin
      status_nxt = ST_IDLE;
    end else if (!s1_item_r.data_ready) begin
      attempts_nxt = att_inc;
      hum_nxt      = pend_kind_r;
      if (att_inc >= max_retry_r) begin
        busy_nxt   = 1'b0;
        status_nxt = ST_COMM;
      end else begin
        status_nxt = ST_PENDING;
      end
    end else begin
      busy_nxt = 1'b0;
      hum_nxt  = pend_kind_r;
      if (crc_calc != s1_item_r.check_byte) begin
        status_nxt = ST_CORRUPT;
      end else begin
        status_nxt = ST_OK;
        value_nxt  = value_full[14:0];
        raw_nxt    = raw_masked;
      end
    end
  end

  // State, configuration and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_kind_r <= 1'b0;
      attempts_r  <= '0;
      max_retry_r <= MAX_RETRY_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        max_retry_r <= cfg_if.data;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          busy_r      <= busy_nxt;
          pend_kind_r <= pend_kind_nxt;
          attempts_r  <= attempts_nxt;
        end
      end
    end
    if (s1_adv && s1_valid_r) begin
      status_r <= status_nxt;
      value_r  <= value_nxt;
      raw_r    <= raw_nxt;
      hum_r    <= hum_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.status       = status_r;
  assign out_if.value        = value_r;
  assign out_if.raw_code     = raw_r;
  assign out_if.was_humidity = hum_r;

`ifndef ASSERT_OFF
  // An accepted item always occupies the input register in the next cycle.
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> s1_valid_r)
    else $error("accepted item lost before input register");

  // Only defined status codes leave the block.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r == ST_PENDING || status_r == ST_OK ||
                     status_r == ST_CORRUPT || status_r == ST_COMM ||
                     status_r == ST_IDLE))
    else $error("undefined status code on result");

  // A good result has its status bits cleared and a value in range.
  a_ok_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_OK) |->
      (raw_r[1:0] == 2'b00 && value_r >= -15'sd4685 && value_r <= 15'sd12887))
    else $error("converted result out of range");

  // A read while no exchange runs reports no measurement kind.
  a_idle_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_IDLE) |-> !hum_r)
    else $error("not-started result carries a kind");
`endif

endmodule

@@ bench/tb_top.sv @@
// Testbench for humidity_temp_frame_reader_unit: directed frames, then random exchanges
// under several retry limits, every result checked against the table or a cycle-free predictor.
// Depends on htfr_pkg, the channel interfaces in htfr_chan_if.sv and the unit itself.
module tb_top;
  import htfr_pkg::*;

  // One result item as the unit reports it.
  typedef struct packed {
    logic [2:0]         status;
    logic signed [14:0] value;
    logic [15:0]        raw_code;
    logic               was_humidity;
  } reading_t;

  // One row of the directed table; typed rows carry their own expected reading.
  typedef struct packed {
    in_item_t item;
    logic     typed;
    reading_t want;
  } probe_t;

  logic clk = 1'b0;
  logic rst_n;

  htfr_in_if  in_ch ();
  htfr_out_if out_ch ();
  htfr_cfg_if cfg_ch ();

  humidity_temp_frame_reader_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Predictor state: the open exchange and the retry limit.
  logic       xchg_busy = 1'b0;
  logic       xchg_hum = KIND_TEMP;
  logic [7:0] xchg_tries = 8'd0;
  logic [7:0] retry_limit = MAX_RETRY_RST;

  reading_t expected_readings[$];
  probe_t   probes[$];
  reading_t no_reading = '0;

  int  items_sent = 0;
  int  readings_checked = 0;
  int  errors = 0;
  int  status_seen[5] = '{default: 0};
  bit  calm = 1'b0;
  bit  hold_armed = 1'b0;

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop in case the unit hangs.
  initial begin
    #3000000;
    $display("humidity_temp_frame_reader_unit: mismatch");
    $finish;
  end

  // CRC-8, polynomial 0x31, init zero, shifted one bit at a time over msb then lsb.
  function automatic logic [7:0] crc8_of_word(input logic [7:0] hi, input logic [7:0] lo);
    logic [15:0] w;
    logic [7:0]  c;
    logic        fb;
    w = {hi, lo};
    c = 8'h00;
    for (int i = 15; i >= 0; i--) begin
      fb = c[7] ^ w[i];
      c = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  function automatic reading_t mk_reading(input logic [2:0] st, input int val,
                                          input logic [15:0] raw, input logic hum);
    reading_t r;
    r.status = st;
    r.value = val[14:0];
    r.raw_code = raw;
    r.was_humidity = hum;
    return r;
  endfunction

  // Fully random input item.
  function automatic in_item_t rand_item();
    logic [31:0] bits;
    bits = $urandom;
    return bits[$bits(in_item_t)-1:0];
  endfunction

  // Start item; the fields that a start ignores are left random.
  function automatic in_item_t mk_start(input logic kind, input logic ok);
    in_item_t it;
    it = rand_item();
    it.action = ACT_START;
    it.kind = kind;
    it.write_ok = ok;
    return it;
  endfunction

  // Read attempt; kind and write_ok are left random.
  function automatic in_item_t mk_read(input logic rdy, input logic [7:0] m,
                                       input logic [7:0] l, input logic [7:0] c);
    in_item_t it;
    it = rand_item();
    it.action = ACT_READ;
    it.data_ready = rdy;
    it.msb = m;
    it.lsb = l;
    it.check_byte = c;
    return it;
  endfunction

  // Advance the exchange by one item and return the reading it should produce.
  function automatic reading_t advance_exchange(input in_item_t it);
    reading_t    r;
    logic [15:0] raw;
    logic [31:0] prod;
    r = mk_reading(ST_IDLE, 0, 16'd0, 1'b0);
    if (it.action == ACT_START) begin
      xchg_tries = 8'd0;
      xchg_busy = it.write_ok;
      if (it.write_ok) begin
        xchg_hum = it.kind;
      end
      r = mk_reading(it.write_ok ? ST_PENDING : ST_COMM, 0, 16'd0, it.kind);
    end else if (xchg_busy) begin
      if (!it.data_ready) begin
        // Short frame: one more retry, give up once the limit is reached.
        if (xchg_tries != 8'hFF) begin
          xchg_tries = xchg_tries + 8'd1;
        end
        if (xchg_tries >= retry_limit) begin
          xchg_busy = 1'b0;
          r = mk_reading(ST_COMM, 0, 16'd0, xchg_hum);
        end else begin
          r = mk_reading(ST_PENDING, 0, 16'd0, xchg_hum);
        end
      end else begin
        xchg_busy = 1'b0;
        if (crc8_of_word(it.msb, it.lsb) != it.check_byte) begin
          r = mk_reading(ST_CORRUPT, 0, 16'd0, xchg_hum);
        end else if (xchg_hum == KIND_HUM) begin
          raw = {it.msb, it.lsb & LSB_MASK_HUM};
          prod = 32'(SCALE_HUM) * 32'(raw);
          r = mk_reading(ST_OK, int'(OFFSET_HUM) + int'(prod[31:16]), raw, KIND_HUM);
        end else begin
          raw = {it.msb, it.lsb & LSB_MASK_TEMP};
          prod = 32'(SCALE_TEMP) * 32'(raw);
          r = mk_reading(ST_OK, int'(OFFSET_TEMP) + int'(prod[31:16]), raw, KIND_TEMP);
        end
      end
    end
    return r;
  endfunction

  // Offer one item, wait for its transfer, then record the expected reading.
  task automatic push_item(input in_item_t it, input logic typed, input reading_t want);
    reading_t guess;
    if (!calm && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= it.action;
    in_ch.kind <= it.kind;
    in_ch.write_ok <= it.write_ok;
    in_ch.data_ready <= it.data_ready;
    in_ch.msb <= it.msb;
    in_ch.lsb <= it.lsb;
    in_ch.check_byte <= it.check_byte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    guess = advance_exchange(it);
    expected_readings.push_back(typed ? want : guess);
    items_sent++;
  endtask

  task automatic send(input in_item_t it);
    push_item(it, 1'b0, no_reading);
  endtask

  task automatic add_probe(input in_item_t it, input logic typed, input reading_t want);
    probe_t p;
    p.item = it;
    p.typed = typed;
    p.want = want;
    probes.push_back(p);
  endtask

  // Write the retry limit once the unit has drained.
  task automatic set_retry_limit(input logic [7:0] limit);
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= limit;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    retry_limit = limit;
  endtask

  // One random exchange: mostly start, a few short frames, then usually a full frame.
  task automatic drive_exchange();
    int         shorts;
    logic [7:0] m;
    logic [7:0] l;
    logic [7:0] chk;
    if ($urandom_range(99) < 12) begin
      send(rand_item());
    end else begin
      send(mk_start(1'($urandom_range(1)), $urandom_range(99) < 90));
      if (retry_limit > 40 || $urandom_range(3) != 0) begin
        shorts = $urandom_range(6);
      end else begin
        shorts = $urandom_range(int'(retry_limit) + 1);
      end
      repeat (shorts) send(mk_read(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                                   8'($urandom_range(255))));
      if ($urandom_range(9) != 0) begin
        m = 8'($urandom_range(255));
        l = 8'($urandom_range(255));
        chk = crc8_of_word(m, l);
        if ($urandom_range(99) < 20) begin
          chk = chk ^ 8'($urandom_range(255, 1));
        end
        send(mk_read(1'b1, m, l, chk));
      end
    end
  endtask

  // Set a limit and run random exchanges under it.
  task automatic run_phase(input logic [7:0] limit, input int n_items);
    int stop_at;
    set_retry_limit(limit);
    // At the highest limit, walk one exchange all the way to its retry limit.
    if (limit == 8'hFF) begin
      send(mk_start(1'($urandom_range(1)), 1'b1));
      repeat (255) send(mk_read(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                                8'($urandom_range(255))));
      send(mk_read(1'b1, 8'h00, 8'h00, 8'h00));
    end
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) drive_exchange();
  endtask

  // Result side: random ready, with one long hold-off so the unit backs up.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && rst_n) begin
        hold_armed = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (80) @(posedge clk);
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 13);
    end
  end

  // Compare each result transfer with the oldest expected reading.
  always @(posedge clk) begin : result_check
    reading_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_readings.size() == 0) begin
        $error("result with nothing expected: status %0d", out_ch.status);
        errors++;
      end else begin
        want = expected_readings.pop_front();
        if (out_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.status);
          errors++;
        end
        if (out_ch.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, out_ch.value);
          errors++;
        end
        if (out_ch.raw_code !== want.raw_code) begin
          $error("raw_code: expected 0x%04h, got 0x%04h", want.raw_code, out_ch.raw_code);
          errors++;
        end
        if (out_ch.was_humidity !== want.was_humidity) begin
          $error("was_humidity: expected %0d, got %0d", want.was_humidity,
                 out_ch.was_humidity);
          errors++;
        end
        readings_checked++;
        if (want.status <= ST_IDLE) begin
          status_seen[want.status]++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases.
  initial begin : stimulus
    probe_t     p;
    logic [7:0] crc_ff;
    in_item_t   it;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.action <= ACT_START;
    in_ch.kind <= KIND_TEMP;
    in_ch.write_ok <= 1'b0;
    in_ch.data_ready <= 1'b0;
    in_ch.msb <= 8'h00;
    in_ch.lsb <= 8'h00;
    in_ch.check_byte <= 8'h00;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset limit.
    crc_ff = crc8_of_word(8'hFF, 8'hFF);
    // Read with no exchange open.
    add_probe(mk_read(1'b1, 8'hA5, 8'h5A, 8'h00), 1'b1, mk_reading(ST_IDLE, 0, 0, 0));
    // Command writes that were not acknowledged.
    add_probe(mk_start(KIND_TEMP, 1'b0), 1'b1, mk_reading(ST_COMM, 0, 0, KIND_TEMP));
    add_probe(mk_start(KIND_HUM, 1'b0), 1'b1, mk_reading(ST_COMM, 0, 0, KIND_HUM));
    add_probe(mk_read(1'b0, 8'h00, 8'h00, 8'h00), 1'b1, mk_reading(ST_IDLE, 0, 0, 0));
    // All-zero frames give the bare offsets.
    add_probe(mk_start(KIND_TEMP, 1'b1), 1'b1, mk_reading(ST_PENDING, 0, 0, KIND_TEMP));
    add_probe(mk_read(1'b1, 8'h00, 8'h00, 8'h00), 1'b1,
              mk_reading(ST_OK, -4685, 0, KIND_TEMP));
    add_probe(mk_start(KIND_HUM, 1'b1), 1'b1, mk_reading(ST_PENDING, 0, 0, KIND_HUM));
    add_probe(mk_read(1'b1, 8'h00, 8'h00, 8'h00), 1'b1,
              mk_reading(ST_OK, -600, 0, KIND_HUM));
    // All-ones frames give the top of each scale.
    add_probe(mk_start(KIND_TEMP, 1'b1), 1'b1, mk_reading(ST_PENDING, 0, 0, KIND_TEMP));
    add_probe(mk_read(1'b1, 8'hFF, 8'hFF, crc_ff), 1'b0, no_reading);
    add_probe(mk_start(KIND_HUM, 1'b1), 1'b1, mk_reading(ST_PENDING, 0, 0, KIND_HUM));
    add_probe(mk_read(1'b1, 8'hFF, 8'hFF, crc_ff), 1'b0, no_reading);
    // Bad check byte, then a read once that exchange has ended.
    add_probe(mk_start(KIND_TEMP, 1'b1), 1'b1, mk_reading(ST_PENDING, 0, 0, KIND_TEMP));
    add_probe(mk_read(1'b1, 8'h12, 8'h34, crc8_of_word(8'h12, 8'h34) ^ 8'hFF), 1'b1,
              mk_reading(ST_CORRUPT, 0, 0, KIND_TEMP));
    add_probe(mk_read(1'b1, 8'h12, 8'h34, 8'h00), 1'b1, mk_reading(ST_IDLE, 0, 0, 0));
    // A short frame, then a new start abandons the open exchange.
    add_probe(mk_start(KIND_HUM, 1'b1), 1'b1, mk_reading(ST_PENDING, 0, 0, KIND_HUM));
    add_probe(mk_read(1'b0, 8'hFF, 8'hFF, 8'hFF), 1'b1,
              mk_reading(ST_PENDING, 0, 0, KIND_HUM));
    add_probe(mk_start(KIND_TEMP, 1'b1), 1'b1, mk_reading(ST_PENDING, 0, 0, KIND_TEMP));
    add_probe(mk_read(1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
              mk_reading(ST_PENDING, 0, 0, KIND_TEMP));
    // A start with data_ready and bytes set, which it ignores.
    it = mk_start(KIND_HUM, 1'b1);
    it.data_ready = 1'b1;
    add_probe(it, 1'b1, mk_reading(ST_PENDING, 0, 0, KIND_HUM));
    // Status bits in the low byte are masked per kind.
    add_probe(mk_read(1'b1, 8'h80, 8'h0F, crc8_of_word(8'h80, 8'h0F)), 1'b0, no_reading);
    add_probe(mk_start(KIND_TEMP, 1'b1), 1'b1, mk_reading(ST_PENDING, 0, 0, KIND_TEMP));
    add_probe(mk_read(1'b1, 8'h80, 8'h03, crc8_of_word(8'h80, 8'h03)), 1'b0, no_reading);
    // A failed write while an exchange is open closes it.
    add_probe(mk_start(KIND_HUM, 1'b1), 1'b1, mk_reading(ST_PENDING, 0, 0, KIND_HUM));
    add_probe(mk_start(KIND_TEMP, 1'b0), 1'b1, mk_reading(ST_COMM, 0, 0, KIND_TEMP));
    add_probe(mk_read(1'b1, 8'h00, 8'h00, 8'h00), 1'b1, mk_reading(ST_IDLE, 0, 0, 0));
    while (probes.size() != 0) begin
      p = probes.pop_front();
      push_item(p.item, p.typed, p.want);
    end

    // Random phases over several retry limits.
    run_phase(8'd1, 160);
    run_phase(8'd0, 160);
    run_phase(8'd255, 160);
    calm = 1'b1;
    run_phase(8'd2, 160);
    calm = 1'b0;
    // Hold the result side off while the sender keeps offering items.
    set_retry_limit(8'd30);
    hold_armed = 1'b1;
    run_phase(8'd30, 160);
    run_phase(8'($urandom_range(20, 3)), 160);
    run_phase(8'($urandom_range(255, 1)), 160);

    // Drain and report.
    in_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Sent %0d items under retry limits 1, 0, 255, 2, 30 and two random ones.",
             items_sent);
    $display("Checked %0d results: %0d pending, %0d ok, %0d corrupt, %0d comm, %0d idle.",
             readings_checked, status_seen[ST_PENDING], status_seen[ST_OK],
             status_seen[ST_CORRUPT], status_seen[ST_COMM], status_seen[ST_IDLE]);
    if (errors == 0) begin
      $display("humidity_temp_frame_reader_unit: match");
    end else begin
      $display("humidity_temp_frame_reader_unit: mismatch");
    end
    $finish;
  end

endmodule
